>>> hdl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Checked only while out of reset.
`define TXC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Checked at every edge, reset included.
`define TXC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

>>> hdl/txc_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Types and fixed codes shared by the console modules.
// ----------------------------------------------------------------------------
`default_nettype none

package txc_pkg;

  localparam int IDX_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 16;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] BLANK_ATTR_RST = 8'd15;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [7:0]       attr;
    logic [IDX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
    logic [IDX_W-1:0] cursor_pos;
    logic             scrolled;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_WRITE,
    ST_HOLD
  } seq_st_t;

endpackage

`default_nettype wire

>>> hdl/txc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/txc_seq.sv
// ----------------------------------------------------------------------------
// Console sequencer
// Cursor tracking, command decode and the sweeps over the cell memory.
// ----------------------------------------------------------------------------
`default_nettype none

module txc_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire txc_pkg::item_t          item,
  input  wire logic [7:0]              blank_attr,
  input  wire logic                    slot_free,
  output logic                         res_valid,
  output txc_pkg::result_t             res,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [txc_pkg::CELL_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_raddr,
  input  wire logic [txc_pkg::CELL_W-1:0] ram_rdata
);

  localparam int CW = $clog2(CELLS + 1);
  localparam int RW = $clog2(ROWS + 1);
  localparam int XW = $clog2(COLUMNS);

  txc_pkg::seq_st_t state_r, state_nxt;
  txc_pkg::item_t   item_r, item_nxt;
  txc_pkg::result_t res_r, res_nxt, res_now;

  logic [CW-1:0] cur_r, cur_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [XW-1:0] col_r, col_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          pend_r, pend_nxt;
  logic          sc_r, sc_nxt;

  logic          is_nl, is_bs, is_chr, need_scroll, idx_ok;
  logic          exec_fin, blank_last, blank_fin, fin;
  logic [31:0]   idx_ext, cur_ext;
  logic [CW-1:0] src_off;

  assign is_nl  = (item_r.kind == txc_pkg::KIND_PUT) &&
                  (item_r.char_code == txc_pkg::CH_NEWLINE);
  assign is_bs  = (item_r.kind == txc_pkg::KIND_PUT) &&
                  (item_r.char_code == txc_pkg::CH_BACKSPACE);
  assign is_chr = (item_r.kind == txc_pkg::KIND_PUT) && !is_nl && !is_bs;

  assign need_scroll = (is_nl && (row_r >= RW'(ROWS - 1))) ||
                       (is_chr && (cur_r >= CW'(CELLS)));

  assign idx_ext = 32'(item_r.cell_index);
  assign idx_ok  = idx_ext < 32'(CELLS);

  assign exec_fin = !need_scroll && (item_r.kind != txc_pkg::KIND_CLEAR) &&
                    !((item_r.kind == txc_pkg::KIND_READ) && idx_ok);

  assign blank_last = (ptr_r == CW'(CELLS - 1));
  assign blank_fin  = blank_last &&
                      ((item_r.kind == txc_pkg::KIND_CLEAR) || is_nl);

  assign src_off = ptr_r - CW'(COLUMNS);

  always_comb begin
    unique case (state_r)
      txc_pkg::ST_EXEC:  fin = exec_fin;
      txc_pkg::ST_READ:  fin = 1'b1;
      txc_pkg::ST_BLANK: fin = blank_fin;
      txc_pkg::ST_WRITE: fin = 1'b1;
      default:           fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      txc_pkg::ST_INIT: begin
        if (blank_last) state_nxt = txc_pkg::ST_IDLE;
      end
      txc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = txc_pkg::ST_EXEC;
      end
      txc_pkg::ST_EXEC: begin
        if (need_scroll) begin
          state_nxt = txc_pkg::ST_SCROLL;
        end else if (item_r.kind == txc_pkg::KIND_CLEAR) begin
          state_nxt = txc_pkg::ST_BLANK;
        end else if ((item_r.kind == txc_pkg::KIND_READ) && idx_ok) begin
          state_nxt = txc_pkg::ST_READ;
        end else begin
          state_nxt = slot_free ? txc_pkg::ST_IDLE : txc_pkg::ST_HOLD;
        end
      end
      txc_pkg::ST_READ: begin
        state_nxt = slot_free ? txc_pkg::ST_IDLE : txc_pkg::ST_HOLD;
      end
      txc_pkg::ST_SCROLL: begin
        if (ptr_r == CW'(CELLS)) state_nxt = txc_pkg::ST_BLANK;
      end
      txc_pkg::ST_BLANK: begin
        if (blank_fin) begin
          state_nxt = slot_free ? txc_pkg::ST_IDLE : txc_pkg::ST_HOLD;
        end else if (blank_last) begin
          state_nxt = txc_pkg::ST_WRITE;
        end
      end
      txc_pkg::ST_WRITE: begin
        state_nxt = slot_free ? txc_pkg::ST_IDLE : txc_pkg::ST_HOLD;
      end
      txc_pkg::ST_HOLD: begin
        if (slot_free) state_nxt = txc_pkg::ST_IDLE;
      end
      default: state_nxt = txc_pkg::ST_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    item_nxt  = item_r;
    cur_nxt   = cur_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    ptr_nxt   = ptr_r;
    wa_nxt    = wa_r;
    pend_nxt  = pend_r;
    sc_nxt    = sc_r;
    ram_we    = 1'b0;
    ram_waddr = cur_r[AW-1:0];
    ram_wdata = {item_r.attr, item_r.char_code};
    ram_re    = 1'b0;
    ram_raddr = item_r.cell_index[AW-1:0];
    in_ready  = 1'b0;

    unique case (state_r)
      txc_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = '0;
        ptr_nxt   = ptr_r + CW'(1);
      end
      txc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) item_nxt = item;
      end
      txc_pkg::ST_EXEC: begin
        sc_nxt = need_scroll;
        if (need_scroll) begin
          ptr_nxt  = CW'(COLUMNS);
          pend_nxt = 1'b0;
          row_nxt  = RW'(ROWS - 1);
          if (is_nl) begin
            cur_nxt = CW'(CELLS - COLUMNS);
            col_nxt = '0;
          end else begin
            cur_nxt = CW'(CELLS - COLUMNS + 1);
            col_nxt = XW'(1);
          end
        end else if (item_r.kind == txc_pkg::KIND_CLEAR) begin
          ptr_nxt = '0;
          cur_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
        end else if (item_r.kind == txc_pkg::KIND_READ) begin
          ram_re = idx_ok;
        end else if (is_nl) begin
          cur_nxt = cur_r - CW'(col_r) + CW'(COLUMNS);
          row_nxt = row_r + RW'(1);
          col_nxt = '0;
        end else if (is_bs) begin
          if (cur_r != '0) begin
            cur_nxt = cur_r - CW'(1);
            if (col_r == '0) begin
              row_nxt = row_r - RW'(1);
              col_nxt = XW'(COLUMNS - 1);
            end else begin
              col_nxt = col_r - XW'(1);
            end
          end
          ram_we    = 1'b1;
          ram_waddr = cur_nxt[AW-1:0];
          ram_wdata = {item_r.attr, txc_pkg::CH_SPACE};
        end else if (is_chr) begin
          ram_we  = 1'b1;
          cur_nxt = cur_r + CW'(1);
          if (col_r == XW'(COLUMNS - 1)) begin
            row_nxt = row_r + RW'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + XW'(1);
          end
        end
      end
      txc_pkg::ST_SCROLL: begin
        // read one row ahead, write the word back a row lower next cycle
        ram_we    = pend_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        if (ptr_r < CW'(CELLS)) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r[AW-1:0];
          pend_nxt  = 1'b1;
          wa_nxt    = src_off[AW-1:0];
          ptr_nxt   = ptr_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          ptr_nxt  = CW'(CELLS - COLUMNS);
        end
      end
      txc_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = {blank_attr, 8'd0};
        ptr_nxt   = ptr_r + CW'(1);
      end
      txc_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(CELLS - COLUMNS);
      end
      txc_pkg::ST_READ,
      txc_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // result assembly
  assign cur_ext = 32'(cur_nxt);

  always_comb begin
    res_now.cursor_pos = cur_ext[txc_pkg::IDX_W-1:0];
    res_now.scrolled   = (state_r == txc_pkg::ST_EXEC) ? 1'b0 : sc_r;
    if (state_r == txc_pkg::ST_READ) begin
      res_now.read_char = ram_rdata[7:0];
      res_now.read_attr = ram_rdata[15:8];
    end else begin
      res_now.read_char = '0;
      res_now.read_attr = '0;
    end
    res_nxt = fin ? res_now : res_r;
  end

  assign res       = (state_r == txc_pkg::ST_HOLD) ? res_r : res_now;
  assign res_valid = slot_free && (fin || (state_r == txc_pkg::ST_HOLD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= txc_pkg::ST_INIT;
      cur_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      sc_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      sc_r    <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    wa_r   <= wa_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/text_console_writer.sv
// Steps from the accepted word to out_valid: a put that needs no scroll, an unused kind
// or an out-of-range read finishes in the execute state, an in-range read adds a read
// state, and a clear blanks every cell. A scroll is a copy pass that moves the rows
// up, then blanks the bottom row, then writes the character when one triggered it.
// A new word is taken only in the idle state, once the last one has finished.
// Reset: sync, active low; a clearing pass follows, no word taken till then.
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console: put, clear and read words against a cell memory.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_attr,
  input  wire logic [10:0] in_cell_index,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_char,
  output logic [7:0]       out_read_attr,
  output logic [10:0]      out_cursor_pos,
  output logic             out_scrolled,
  // blank attribute register
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  txc_pkg::item_t   item;
  txc_pkg::result_t res;
  logic             res_valid;
  logic             slot_free;

  logic [7:0] blank_attr_r, blank_attr_nxt;
  logic       out_valid_r, out_valid_nxt;
  txc_pkg::result_t out_r, out_nxt;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [txc_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign item = {in_kind, in_char_code, in_attr, in_cell_index};

  // Blank attribute: applies to cells cleared by a scroll or a clear.
  assign blank_attr_nxt = cfg_wr_en ? cfg_wr_data : blank_attr_r;

  // Output register: the sequencer can take the next word while a result
  // still waits here; it only stalls when it finishes into a full slot.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_nxt = res_valid ? res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_attr_r <= txc_pkg::BLANK_ATTR_RST;
      out_valid_r  <= 1'b0;
    end else begin
      blank_attr_r <= blank_attr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = out_r.read_char;
  assign out_read_attr  = out_r.read_attr;
  assign out_cursor_pos = out_r.cursor_pos;
  assign out_scrolled   = out_r.scrolled;

  // Cell memory: attribute in the high byte, character in the low byte.
  txc_ram #(
    .WIDTH (txc_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  txc_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item       (item),
    .blank_attr (blank_attr_r),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/txc_chk.sv
// ----------------------------------------------------------------------------
// Console port checker
// Port-level checks on the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_assert.svh"

module txc_chk #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] out_cursor_pos,
  input wire logic        out_scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam logic [10:0] LAST_ROW0 = 11'(CELLS - COLUMNS);
  localparam logic [10:0] LAST_ROW1 = 11'(CELLS - COLUMNS + 1);

  logic stall;
  logic on_last;

  assign stall   = out_valid && !out_ready;
  assign on_last = (out_cursor_pos == LAST_ROW0) || (out_cursor_pos == LAST_ROW1);

  // a waiting result keeps its cursor
  `TXC_ASSERT(a_out_hold, clk, rst_n, stall |=> out_valid && $stable(out_cursor_pos))

  // cursor never goes beyond one past the last cell
  `TXC_ASSERT(a_cursor_range, clk, rst_n, out_valid |-> 32'(out_cursor_pos) <= 32'(CELLS))

  // after a scroll the cursor sits on the last row, column 0 or 1
  `TXC_ASSERT(a_scroll_cursor, clk, rst_n, out_valid && out_scrolled |-> on_last)

  // reset starts the clearing pass, no word taken
  `TXC_ASSERT_ALWAYS(a_init_pass, clk, !rst_n |=> !in_ready)

endmodule

bind text_console_writer txc_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_txc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cursor_pos (out_cursor_pos),
  .out_scrolled   (out_scrolled)
);

`default_nettype wire

>>> bench/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear, read and unused words through the valid/ready channel,
// keeps a shadow screen and cursor that predict every status word, and checks
// each returned word field by field. Covers the blank attribute register at
// its reset value, both extremes and a random value, scrolls from a newline on
// the last row and from a character past the end, and backspace at both ends.
// ----------------------------------------------------------------------------

module text_console_writer_tb;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // No package name for the fourth kind; the block must treat it as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every bench-driven signal starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_attr = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;
  logic [10:0] out_cursor_pos;
  logic        out_scrolled;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  always #4 clk = ~clk;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .in_attr       (in_attr),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr),
    .out_cursor_pos(out_cursor_pos),
    .out_scrolled  (out_scrolled),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Shadow console: screen, cursor and blank attribute as the block should
  // hold them. The reset clearing pass leaves every cell zero.
  // --------------------------------------------------------------------------
  logic [15:0] shadow_cells [CELLS] = '{default: '0};
  int          shadow_cursor = 0;
  logic [7:0]  shadow_blank_attr = txc_pkg::BLANK_ATTR_RST;

  txc_pkg::item_t   queued_words [$];   // words waiting for the driver
  txc_pkg::result_t owed_status [$];    // status words owed by the block, oldest first
  int          planned_words = 0;  // words that the block acts on (kind 3 excluded)
  int          fail_count = 0;
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 54;

  // Rows move up one; the freed bottom row takes char 0 and the blank attribute.
  function automatic void shift_rows_up();
    for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_blank_attr, 8'h00};
  endfunction

  // Apply one accepted word to the shadow console and return the status word.
  function automatic txc_pkg::result_t apply_console_word(input txc_pkg::item_t w);
    txc_pkg::result_t r;
    int      pos;
    r   = '0;
    pos = (shadow_cursor > CELLS) ? CELLS : shadow_cursor;
    unique case (w.kind)
      txc_pkg::KIND_PUT: begin
        if (w.char_code == txc_pkg::CH_NEWLINE) begin
          // last row or past the end: scroll and land on the last row start
          if (pos / COLS >= ROWS - 1) begin
            shift_rows_up();
            r.scrolled = 1'b1;
            pos = CELLS - COLS;
          end else begin
            pos = (pos / COLS + 1) * COLS;
          end
        end else if (w.char_code == txc_pkg::CH_BACKSPACE) begin
          // saturates at cell 0, which is still blanked
          if (pos > 0) pos--;
          shadow_cells[pos] = {w.attr, txc_pkg::CH_SPACE};
        end else begin
          // past the end: scroll first, the char goes to the last row start
          if (pos >= CELLS) begin
            shift_rows_up();
            r.scrolled = 1'b1;
            pos = CELLS - COLS;
          end
          shadow_cells[pos] = {w.attr, w.char_code};
          pos++;
        end
      end
      txc_pkg::KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_blank_attr, 8'h00};
        pos = 0;
      end
      txc_pkg::KIND_READ: begin
        if (w.cell_index < CELLS) begin
          r.read_char = shadow_cells[w.cell_index][7:0];
          r.read_attr = shadow_cells[w.cell_index][15:8];
        end
      end
      default: ;
    endcase
    shadow_cursor = pos;
    r.cursor_pos  = 11'(pos);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void push_word(input logic [1:0] k, input logic [7:0] c,
                                    input logic [7:0] a, input logic [10:0] i);
    queued_words.push_back(txc_pkg::item_t'{kind: k, char_code: c, attr: a, cell_index: i});
    if (k != KIND_UNUSED) planned_words++;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [10:0] any_index();
    return 11'($urandom_range(2047));
  endfunction

  // mostly printable, with newlines, backspaces and arbitrary bytes mixed in
  function automatic logic [7:0] pick_text_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return 8'($urandom_range(32, 126));
    if (p < 78) return txc_pkg::CH_NEWLINE;
    if (p < 88) return txc_pkg::CH_BACKSPACE;
    return any_byte();
  endfunction

  // any byte that is neither newline nor backspace
  function automatic logic [7:0] pick_plain_char();
    logic [7:0] c;
    c = any_byte();
    if (c == txc_pkg::CH_NEWLINE || c == txc_pkg::CH_BACKSPACE) c = c ^ 8'h40;
    return c;
  endfunction

  // bias reads toward the top rows and the bottom rows, where text lands
  function automatic logic [10:0] pick_read_index();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 35) return 11'($urandom_range(0, 2 * COLS - 1));
    if (p < 60) return 11'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
    if (p < 90) return 11'($urandom_range(0, CELLS - 1));
    return 11'($urandom_range(CELLS, 2047));
  endfunction

  // clear, then walk the cursor down to the start of the last row
  function automatic void add_descend();
    push_word(txc_pkg::KIND_CLEAR, any_byte(), any_byte(), any_index());
    repeat (ROWS - 1)
      push_word(txc_pkg::KIND_PUT, txc_pkg::CH_NEWLINE, any_byte(), any_index());
  endfunction

  // fill the last row so the cursor sits past the end, then poke that state
  function automatic void add_overrun(input bit char_tail);
    add_descend();
    repeat (COLS) push_word(txc_pkg::KIND_PUT, pick_plain_char(), any_byte(), any_index());
    if (char_tail) begin
      // char past the end: scroll, char lands on the last row start
      push_word(txc_pkg::KIND_PUT, pick_plain_char(), any_byte(), any_index());
      push_word(txc_pkg::KIND_READ, any_byte(), any_byte(), 11'(CELLS - COLS));
      push_word(txc_pkg::KIND_READ, any_byte(), any_byte(), 11'(CELLS - COLS - 1));
    end else begin
      // backspace from past the end, refill, then newline past the end
      push_word(txc_pkg::KIND_PUT, txc_pkg::CH_BACKSPACE, any_byte(), any_index());
      push_word(txc_pkg::KIND_READ, any_byte(), any_byte(), 11'(CELLS - 1));
      push_word(txc_pkg::KIND_PUT, pick_plain_char(), any_byte(), any_index());
      push_word(txc_pkg::KIND_PUT, txc_pkg::CH_NEWLINE, any_byte(), any_index());
      push_word(txc_pkg::KIND_READ, any_byte(), any_byte(), 11'(CELLS - COLS - 1));
    end
  endfunction

  // random sequences until the planned word count reaches stop_at
  function automatic void fill_random(input int stop_at);
    int unsigned pick;
    while (planned_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 12))
          push_word(txc_pkg::KIND_PUT, pick_text_char(), any_byte(), any_index());
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4))
          push_word(txc_pkg::KIND_READ, any_byte(), any_byte(), pick_read_index());
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 2))
          push_word(KIND_UNUSED, any_byte(), any_byte(), any_index());
      end else if (pick < 87) begin
        push_word(txc_pkg::KIND_CLEAR, any_byte(), any_byte(), any_index());
      end else if (pick < 93) begin
        add_descend();
      end else begin
        // newline burst; scrolls when the cursor is on the last row
        repeat ($urandom_range(1, 3))
          push_word(txc_pkg::KIND_PUT, txc_pkg::CH_NEWLINE, any_byte(), any_index());
        push_word(txc_pkg::KIND_READ, any_byte(), any_byte(),
                  11'($urandom_range(CELLS - 2 * COLS, CELLS - 1)));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued words, holds each until accepted, and predicts the
  // status word at the edge where the block takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    txc_pkg::item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        owed_status.push_back(apply_console_word(
            txc_pkg::item_t'{kind: in_kind, char_code: in_char_code, attr: in_attr,
                             cell_index: in_cell_index}));
      if (!in_valid || in_ready) begin
        if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_words.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= nxt.kind;
          in_char_code  <= nxt.char_code;
          in_attr       <= nxt.attr;
          in_cell_index <= nxt.cell_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, and every returned word checked against the
  // oldest owed status word.
  // --------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [10:0] want,
                              input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_status
    txc_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_status.size() == 0) begin
          $display("%0t: status word with none owed, cursor %0d", $time, out_cursor_pos);
          fail_count++;
        end else begin
          want = owed_status.pop_front();
          report_field("read_char", 11'(want.read_char), 11'(out_read_char));
          report_field("read_attr", 11'(want.read_attr), 11'(out_read_attr));
          report_field("cursor_pos", want.cursor_pos, out_cursor_pos);
          report_field("scrolled", 11'(want.scrolled), 11'(out_scrolled));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // wait until nothing is queued, offered or owed
  task automatic wait_console_idle();
    while (queued_words.size() != 0 || in_valid || owed_status.size() != 0)
      @(posedge clk);
  endtask

  // register write lands at the next edge; shadow follows at that edge
  task automatic set_blank_attr(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_blank_attr = value;
  endtask

  initial begin : run_console
    int phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the blank attribute at its reset value.
    @(negedge clk);
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'd0);     // untouched cell reads zero
    push_word(KIND_UNUSED,         8'hFF, 8'hFF, 11'd2047);  // unused kind, all ones
    push_word(txc_pkg::KIND_PUT,   8'h48, 8'h00, 11'd0);
    push_word(txc_pkg::KIND_PUT,   8'hFF, 8'hFF, 11'd2047);
    push_word(txc_pkg::KIND_PUT,   8'h00, 8'h5A, 11'd0);     // char 0 is written as is
    push_word(txc_pkg::KIND_READ,  8'hFF, 8'hFF, 11'd1);
    push_word(txc_pkg::KIND_PUT,   txc_pkg::CH_BACKSPACE, 8'hA5, 11'd0); // back one, blank
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'd2);
    push_word(txc_pkg::KIND_PUT,   txc_pkg::CH_NEWLINE, 8'h00, 11'd0);   // to row 1 start
    push_word(txc_pkg::KIND_PUT,   8'h78, 8'h1E, 11'd0);
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'(COLS));
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'(CELLS - 1));
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'(CELLS)); // first index out of range
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'd2047);
    push_word(txc_pkg::KIND_CLEAR, 8'h00, 8'h00, 11'd0);     // blanks with reset attr
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'd5);
    push_word(txc_pkg::KIND_PUT,   txc_pkg::CH_BACKSPACE, 8'h3C, 11'd0); // at cell zero
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'd0);
    push_word(txc_pkg::KIND_PUT,   txc_pkg::CH_BACKSPACE, 8'hC3, 11'd0);
    push_word(txc_pkg::KIND_READ,  8'h00, 8'h00, 11'(CELLS - 1));
    wait_console_idle();

    // Phase A: sender idles 22%, receiver 54%; all-ones blank attribute.
    set_blank_attr(8'hFF);
    @(negedge clk);
    phase_end = planned_words + 150;
    add_descend();
    fill_random(phase_end);
    wait_console_idle();

    // Phase B: idling swapped; all-zeros blank attribute.
    set_blank_attr(8'h00);
    @(negedge clk);
    send_idle_pct = 54;
    recv_idle_pct = 22;
    phase_end = planned_words + 150;
    add_overrun(1'b0);
    fill_random(phase_end);
    wait_console_idle();

    // Phase C: no idling on either side; random blank attribute.
    set_blank_attr(8'($urandom_range(1, 254)));
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_end = planned_words + 150;
    add_overrun(1'b1);
    fill_random(phase_end);
    wait_console_idle();

    // let any stray status word surface
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit: far above the slowest expected run.
  initial begin : run_limit
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
